@@ rtl/hkrq_pkg.sv @@
// Shared types and constants for the HID key report queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package hkrq_pkg;

	localparam logic [3:0] FN_PRESS    = 4'd0;
	localparam logic [3:0] FN_RELEASE  = 4'd1;
	localparam logic [3:0] FN_REL_ALL  = 4'd2;
	localparam logic [3:0] FN_FLUSH    = 4'd3;
	localparam logic [3:0] FN_RAW      = 4'd4;
	localparam logic [3:0] FN_COMPLETE = 4'd5;
	localparam logic [3:0] FN_FAILED   = 4'd6;
	localparam logic [3:0] FN_UNMOUNT  = 4'd7;
	localparam logic [3:0] FN_READ     = 4'd8;

	localparam int unsigned KEY_SLOTS   = 6;
	localparam int unsigned COUNT_DEPTH = 256;
	localparam logic [7:0]  COUNT_MAX   = 8'hFF;
	localparam logic [4:0]  MOD_PREFIX  = 5'b11100;

	typedef struct packed {
		logic [7:0]                modifier;
		logic [KEY_SLOTS-1:0][7:0] keys;
	} report_t;

	typedef struct packed {
		logic take;
		logic cnt_rd;
		logic press_upd;
		logic rel_upd;
		logic scan_rd;
		logic scan_chk;
		logic scan_end;
		logic clr_all;
		logic q_desired;
		logic q_dirty;
		logic push_raw;
		logic complete_upd;
		logic fail_upd;
		logic unmount_upd;
		logic resync;
		logic snap_rd;
		logic snap_cap;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [3:0] func;
		logic       key_zero;
		logic       need_scan;
		logic       scan_more;
		logic       can_send;
		logic       inflight;
		logic       fill_nz;
		logic       mounted;
		logic       raw_ok;
		logic       out_free;
	} stat_t;

endpackage

@@ rtl/hkrq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hkrq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/hkrq_ctrl.sv @@
// Sequencer for the HID key report queue: walks each request through its steps.
// Depends on hkrq_pkg (cmd_t, stat_t, function codes).
module hkrq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  hkrq_pkg::stat_t stat,
	output hkrq_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_CNT,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SCAN_END,
		S_QDES,
		S_P_RS,
		S_P_CHK,
		S_P_CAP,
		S_FIN
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.func)
					hkrq_pkg::FN_PRESS, hkrq_pkg::FN_RELEASE: begin
						if (stat.key_zero) begin
							state_nxt = S_FIN;
						end else begin
							cmd.cnt_rd = 1'b1;
							state_nxt  = S_CNT;
						end
					end
					hkrq_pkg::FN_REL_ALL: begin
						cmd.clr_all = 1'b1;
						state_nxt   = S_QDES;
					end
					hkrq_pkg::FN_FLUSH: begin
						cmd.q_dirty = 1'b1;
						state_nxt   = S_P_RS;
					end
					hkrq_pkg::FN_RAW: begin
						if (stat.mounted) begin
							// a refused snapshot still counts an overflow but sends nothing
							cmd.push_raw = 1'b1;
							state_nxt    = stat.raw_ok ? S_P_RS : S_FIN;
						end else begin
							state_nxt = S_FIN;
						end
					end
					hkrq_pkg::FN_COMPLETE: begin
						if (stat.inflight && stat.fill_nz) begin
							cmd.complete_upd = 1'b1;
							state_nxt        = S_P_RS;
						end else begin
							state_nxt = S_FIN;
						end
					end
					hkrq_pkg::FN_FAILED: begin
						if (stat.inflight) begin
							cmd.fail_upd = 1'b1;
							state_nxt    = S_P_RS;
						end else begin
							state_nxt = S_FIN;
						end
					end
					hkrq_pkg::FN_UNMOUNT: begin
						cmd.unmount_upd = 1'b1;
						state_nxt       = S_FIN;
					end
					default: begin
						state_nxt = S_FIN;
					end
				endcase
			end
			S_CNT: begin
				if (stat.func == hkrq_pkg::FN_PRESS) begin
					cmd.press_upd = 1'b1;
					state_nxt     = S_FIN;
				end else begin
					cmd.rel_upd = 1'b1;
					state_nxt   = stat.need_scan ? S_SCAN_RD : S_FIN;
				end
			end
			S_SCAN_RD: begin
				if (stat.scan_more) begin
					cmd.scan_rd = 1'b1;
					state_nxt   = S_SCAN_CHK;
				end else begin
					state_nxt = S_SCAN_END;
				end
			end
			S_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				state_nxt    = S_SCAN_RD;
			end
			S_SCAN_END: begin
				cmd.scan_end = 1'b1;
				state_nxt    = S_FIN;
			end
			S_QDES: begin
				cmd.q_desired = 1'b1;
				state_nxt     = S_P_RS;
			end
			S_P_RS: begin
				cmd.resync = 1'b1;
				state_nxt  = S_P_CHK;
			end
			S_P_CHK: begin
				if (stat.can_send) begin
					cmd.snap_rd = 1'b1;
					state_nxt   = S_P_CAP;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_P_CAP: begin
				cmd.snap_cap = 1'b1;
				state_nxt    = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

@@ rtl/hkrq_dpath.sv @@
// Datapath of the HID key report queue: press counts, held list, report queue, totals.
// Depends on hkrq_pkg and hkrq_ram.
module hkrq_dpath #(
	parameter int unsigned MAX_HELD    = 128,
	parameter int unsigned QUEUE_DEPTH = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hkrq_pkg::cmd_t  cmd,
	output hkrq_pkg::stat_t stat,
	input  logic [3:0]      func,
	input  logic [7:0]      key_code,
	input  logic [7:0]      modifier_in,
	input  logic [7:0]      raw_key0,
	input  logic [7:0]      raw_key1,
	input  logic [7:0]      raw_key2,
	input  logic [7:0]      raw_key3,
	input  logic [7:0]      raw_key4,
	input  logic [7:0]      raw_key5,
	input  logic            host_mounted,
	input  logic            link_ready,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            send_valid,
	output logic [7:0]      out_modifier,
	output logic [7:0]      out_key0,
	output logic [7:0]      out_key1,
	output logic [7:0]      out_key2,
	output logic [7:0]      out_key3,
	output logic [7:0]      out_key4,
	output logic [7:0]      out_key5,
	output logic            accepted,
	output logic            transport_idle,
	output logic [31:0]     overflow_count,
	output logic [31:0]     failed_count
);

	localparam int unsigned HT_W = $clog2(MAX_HELD + 1);
	localparam int unsigned LA_W = $clog2(MAX_HELD);
	localparam int unsigned PA_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned FL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned REP_W = $bits(hkrq_pkg::report_t);

	logic [3:0]                       func_q;
	logic [7:0]                       key_q;
	hkrq_pkg::report_t                raw_q;
	logic                             mounted_q;
	logic                             ready_q;
	logic [hkrq_pkg::COUNT_DEPTH-1:0] cnt_vld_q;
	logic [7:0]                       mod_q;
	logic                             dirty_q;
	logic [HT_W-1:0]                  ht_q;
	logic [hkrq_pkg::KEY_SLOTS-1:0][7:0] mirror_q;
	logic [HT_W-1:0]                  idx_q;
	logic                             found_q;
	logic [PA_W-1:0]                  rptr_q;
	logic [PA_W-1:0]                  wptr_q;
	logic [FL_W-1:0]                  fill_q;
	logic                             inflight_q;
	logic                             resync_q;
	logic [31:0]                      ovf_q;
	logic [31:0]                      fail_q;
	hkrq_pkg::report_t                last_q;
	hkrq_pkg::report_t                sent_q;
	logic                             acc_q;
	logic                             sent_now_q;
	logic                             out_valid_q;
	hkrq_pkg::report_t                out_rep_q;
	logic                             out_send_q;
	logic                             out_acc_q;
	logic                             out_idle_q;
	logic [31:0]                      out_ovf_q;
	logic [31:0]                      out_fail_q;

	logic [7:0]        cnt_rdata;
	logic [7:0]        cnt_cur;
	logic [7:0]        cnt_wdata;
	logic              cnt_we;
	logic [7:0]        list_rdata;
	logic              list_we;
	logic [LA_W-1:0]   list_waddr;
	logic [7:0]        list_wdata;
	logic [REP_W-1:0]  snap_rdata;
	logic              is_mod;
	logic [7:0]        mod_bit;
	logic              held_room;
	logic              press_new;
	logic [HT_W-1:0]   idx_m1;
	logic [HT_W-1:0]   ht_m1;
	hkrq_pkg::report_t desired;
	hkrq_pkg::report_t push_rep;
	logic              full;
	logic              fill_nz;
	logic              resync_go;
	logic              push_en;
	logic              dup;
	logic              push_ok;
	logic              push_wr;
	logic              push_ovf;

	function automatic logic [PA_W-1:0] ptr_next(input logic [PA_W-1:0] p);
		return (p == PA_W'(QUEUE_DEPTH - 1)) ? '0 : p + PA_W'(1);
	endfunction

	assign cnt_cur   = cnt_vld_q[key_q] ? cnt_rdata : 8'd0;
	assign is_mod    = (key_q[7:3] == hkrq_pkg::MOD_PREFIX);
	assign mod_bit   = 8'b1 << key_q[2:0];
	assign held_room = (ht_q < HT_W'(MAX_HELD));
	assign press_new = cmd.press_upd && (cnt_cur == 8'd0);
	assign idx_m1    = idx_q - HT_W'(1);
	assign ht_m1     = ht_q - HT_W'(1);

	assign desired.modifier = mod_q;
	assign desired.keys     = mirror_q;

	assign full      = (fill_q == FL_W'(QUEUE_DEPTH));
	assign fill_nz   = (fill_q != '0);
	assign resync_go = resync_q && mounted_q && !full;

	// One snapshot push per cycle, from whichever step asks for it
	assign push_rep = cmd.push_raw ? raw_q : desired;
	assign push_en  = cmd.push_raw || (cmd.q_desired && mounted_q) ||
	                  (cmd.q_dirty && dirty_q && mounted_q) || (cmd.resync && resync_go);
	assign dup      = fill_nz && (last_q == push_rep);
	assign push_ok  = dup || !full;
	assign push_wr  = push_en && !dup && !full;
	assign push_ovf = push_en && !dup && full;

	// A count that saturates blocks the press; a new key with the list full is dropped
	assign cnt_we = (cmd.press_upd && (cnt_cur != hkrq_pkg::COUNT_MAX)) ||
	                (cmd.rel_upd && (cnt_cur != 8'd0));
	always_comb begin
		if (cmd.press_upd) begin
			cnt_wdata = (press_new && !is_mod && !held_room) ? 8'd0 : cnt_cur + 8'd1;
		end else begin
			cnt_wdata = cnt_cur - 8'd1;
		end
	end

	assign list_we    = (press_new && !is_mod && held_room) || (cmd.scan_chk && found_q);
	assign list_waddr = cmd.scan_chk ? idx_m1[LA_W-1:0] : ht_q[LA_W-1:0];
	assign list_wdata = cmd.scan_chk ? list_rdata : key_q;

	hkrq_ram #(
		.WIDTH(8),
		.DEPTH(hkrq_pkg::COUNT_DEPTH)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(key_q),
		.wdata(cnt_wdata),
		.re   (cmd.cnt_rd),
		.raddr(key_q),
		.rdata(cnt_rdata)
	);

	hkrq_ram #(
		.WIDTH(8),
		.DEPTH(MAX_HELD)
	) u_list_ram (
		.clk  (clk),
		.we   (list_we),
		.waddr(list_waddr),
		.wdata(list_wdata),
		.re   (cmd.scan_rd),
		.raddr(idx_q[LA_W-1:0]),
		.rdata(list_rdata)
	);

	hkrq_ram #(
		.WIDTH(REP_W),
		.DEPTH(QUEUE_DEPTH)
	) u_snap_ram (
		.clk  (clk),
		.we   (push_wr),
		.waddr(wptr_q),
		.wdata(push_rep),
		.re   (cmd.snap_rd),
		.raddr(rptr_q),
		.rdata(snap_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q      <= '0;
			key_q       <= '0;
			raw_q       <= '0;
			mounted_q   <= 1'b0;
			ready_q     <= 1'b0;
			cnt_vld_q   <= '0;
			mod_q       <= '0;
			dirty_q     <= 1'b0;
			ht_q        <= '0;
			mirror_q    <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			rptr_q      <= '0;
			wptr_q      <= '0;
			fill_q      <= '0;
			inflight_q  <= 1'b0;
			resync_q    <= 1'b0;
			ovf_q       <= '0;
			fail_q      <= '0;
			last_q      <= '0;
			sent_q      <= '0;
			acc_q       <= 1'b0;
			sent_now_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_rep_q   <= '0;
			out_send_q  <= 1'b0;
			out_acc_q   <= 1'b0;
			out_idle_q  <= 1'b0;
			out_ovf_q   <= '0;
			out_fail_q  <= '0;
		end else begin
			if (cmd.take) begin
				func_q           <= func;
				key_q            <= key_code;
				raw_q.modifier   <= modifier_in;
				raw_q.keys[0]    <= raw_key0;
				raw_q.keys[1]    <= raw_key1;
				raw_q.keys[2]    <= raw_key2;
				raw_q.keys[3]    <= raw_key3;
				raw_q.keys[4]    <= raw_key4;
				raw_q.keys[5]    <= raw_key5;
				mounted_q        <= host_mounted;
				ready_q          <= link_ready;
				acc_q            <= (func == hkrq_pkg::FN_READ);
				sent_now_q       <= 1'b0;
			end

			if (cnt_we) begin
				cnt_vld_q[key_q] <= 1'b1;
			end

			if (press_new) begin
				if (is_mod) begin
					if ((mod_q & mod_bit) == 8'd0) begin
						mod_q   <= mod_q | mod_bit;
						dirty_q <= 1'b1;
					end
				end else if (held_room) begin
					if (ht_q < HT_W'(hkrq_pkg::KEY_SLOTS)) begin
						mirror_q[ht_q[2:0]] <= key_q;
					end
					ht_q    <= ht_q + HT_W'(1);
					dirty_q <= 1'b1;
				end
			end

			if (cmd.rel_upd) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				if ((cnt_cur == 8'd1) && is_mod && ((mod_q & mod_bit) != 8'd0)) begin
					mod_q   <= mod_q & ~mod_bit;
					dirty_q <= 1'b1;
				end
			end

			// Walk the list; once the key is found, move each later entry down one place
			if (cmd.scan_chk) begin
				if (found_q) begin
					if (idx_m1 < HT_W'(hkrq_pkg::KEY_SLOTS)) begin
						mirror_q[idx_m1[2:0]] <= list_rdata;
					end
				end else if (list_rdata == key_q) begin
					found_q <= 1'b1;
				end
				idx_q <= idx_q + HT_W'(1);
			end

			if (cmd.scan_end && found_q) begin
				ht_q    <= ht_m1;
				dirty_q <= 1'b1;
				if (ht_m1 < HT_W'(hkrq_pkg::KEY_SLOTS)) begin
					mirror_q[ht_m1[2:0]] <= 8'd0;
				end
			end

			if (cmd.clr_all) begin
				mod_q     <= '0;
				dirty_q   <= 1'b0;
				ht_q      <= '0;
				mirror_q  <= '0;
				cnt_vld_q <= '0;
				resync_q  <= 1'b0;
				// Keep only the report on the wire, if there is one
				if (inflight_q && fill_nz) begin
					wptr_q <= ptr_next(rptr_q);
					fill_q <= FL_W'(1);
					last_q <= sent_q;
				end else begin
					rptr_q     <= '0;
					wptr_q     <= '0;
					fill_q     <= '0;
					inflight_q <= 1'b0;
				end
			end

			if (cmd.q_desired) begin
				acc_q <= !mounted_q || push_ok;
				if (!mounted_q) begin
					resync_q <= 1'b1;
				end
			end

			if (cmd.q_dirty && dirty_q) begin
				dirty_q <= 1'b0;
				if (!mounted_q) begin
					resync_q <= 1'b1;
				end
			end

			if (cmd.push_raw) begin
				acc_q <= push_ok;
			end

			if (cmd.resync && resync_go) begin
				resync_q <= 1'b0;
			end

			if (push_wr) begin
				last_q <= push_rep;
				wptr_q <= ptr_next(wptr_q);
				fill_q <= fill_q + FL_W'(1);
			end

			if (push_ovf) begin
				ovf_q    <= ovf_q + 32'd1;
				resync_q <= 1'b1;
			end

			if (cmd.complete_upd) begin
				acc_q      <= 1'b1;
				inflight_q <= 1'b0;
				rptr_q     <= ptr_next(rptr_q);
				fill_q     <= fill_q - FL_W'(1);
			end

			if (cmd.fail_upd) begin
				acc_q      <= 1'b1;
				inflight_q <= 1'b0;
				fail_q     <= fail_q + 32'd1;
			end

			if (cmd.unmount_upd) begin
				rptr_q     <= '0;
				wptr_q     <= '0;
				fill_q     <= '0;
				inflight_q <= 1'b0;
				dirty_q    <= 1'b0;
				resync_q   <= 1'b1;
			end

			if (cmd.snap_cap) begin
				sent_q     <= hkrq_pkg::report_t'(snap_rdata);
				inflight_q <= 1'b1;
				sent_now_q <= 1'b1;
				if (func_q == hkrq_pkg::FN_FLUSH) begin
					acc_q <= 1'b1;
				end
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				out_send_q  <= sent_now_q;
				if (sent_now_q) begin
					out_rep_q <= sent_q;
				end else if (func_q == hkrq_pkg::FN_READ) begin
					out_rep_q <= desired;
				end else begin
					out_rep_q <= '0;
				end
				out_acc_q  <= acc_q;
				out_idle_q <= !mounted_q ||
				              (!dirty_q && !inflight_q && !fill_nz && !resync_q);
				out_ovf_q  <= ovf_q;
				out_fail_q <= fail_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat           = '0;
		stat.func      = func_q;
		stat.key_zero  = (key_q == 8'd0);
		stat.need_scan = (cnt_cur == 8'd1) && !is_mod;
		stat.scan_more = (idx_q < ht_q);
		stat.can_send  = !inflight_q && fill_nz && mounted_q && ready_q;
		stat.inflight  = inflight_q;
		stat.fill_nz   = fill_nz;
		stat.mounted   = mounted_q;
		stat.raw_ok    = (fill_nz && (last_q == raw_q)) || !full;
		stat.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid      = out_valid_q;
	assign send_valid     = out_send_q;
	assign out_modifier   = out_rep_q.modifier;
	assign out_key0       = out_rep_q.keys[0];
	assign out_key1       = out_rep_q.keys[1];
	assign out_key2       = out_rep_q.keys[2];
	assign out_key3       = out_rep_q.keys[3];
	assign out_key4       = out_rep_q.keys[4];
	assign out_key5       = out_rep_q.keys[5];
	assign accepted       = out_acc_q;
	assign transport_idle = out_idle_q;
	assign overflow_count = out_ovf_q;
	assign failed_count   = out_fail_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FL_W'(QUEUE_DEPTH))
		else $error("queue fill level beyond depth");

	a_inflight_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q |-> fill_nz)
		else $error("report in flight with empty queue");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ht_q <= HT_W'(MAX_HELD))
		else $error("held list count beyond capacity");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push_wr |=> fill_nz)
		else $error("queue empty after a snapshot was written");
`endif

endmodule

@@ rtl/hid_key_report_queue_core.sv @@
// Top level of the HID boot-keyboard report queue: sequencer plus datapath.
// Depends on hkrq_pkg, hkrq_ctrl, hkrq_dpath and hkrq_ram.
//
// One request is taken at a time; stall stays high until its result is loaded into
// the output register, and the next request can be taken while that result waits.
// Releasing the last press of a non-modifier key walks the held-key RAM, with a read
// step and a check step per held entry; that walk through the held list, read one
// entry at a time, sets the worst case. Press counts clear at once on reset and on
// release-all through per-usage valid bits; there is no clearing pass. The report
// queue holds QUEUE_DEPTH snapshots.
module hid_key_report_queue_core #(
	parameter int unsigned MAX_HELD    = 128,
	parameter int unsigned QUEUE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  func,
	input  logic [7:0]  key_code,
	input  logic [7:0]  modifier_in,
	input  logic [7:0]  raw_key0,
	input  logic [7:0]  raw_key1,
	input  logic [7:0]  raw_key2,
	input  logic [7:0]  raw_key3,
	input  logic [7:0]  raw_key4,
	input  logic [7:0]  raw_key5,
	input  logic        host_mounted,
	input  logic        link_ready,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        send_valid,
	output logic [7:0]  out_modifier,
	output logic [7:0]  out_key0,
	output logic [7:0]  out_key1,
	output logic [7:0]  out_key2,
	output logic [7:0]  out_key3,
	output logic [7:0]  out_key4,
	output logic [7:0]  out_key5,
	output logic        accepted,
	output logic        transport_idle,
	output logic [31:0] overflow_count,
	output logic [31:0] failed_count
);

	hkrq_pkg::cmd_t  cmd;
	hkrq_pkg::stat_t stat;

	hkrq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	hkrq_dpath #(
		.MAX_HELD   (MAX_HELD),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.key_code      (key_code),
		.modifier_in   (modifier_in),
		.raw_key0      (raw_key0),
		.raw_key1      (raw_key1),
		.raw_key2      (raw_key2),
		.raw_key3      (raw_key3),
		.raw_key4      (raw_key4),
		.raw_key5      (raw_key5),
		.host_mounted  (host_mounted),
		.link_ready    (link_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.send_valid    (send_valid),
		.out_modifier  (out_modifier),
		.out_key0      (out_key0),
		.out_key1      (out_key1),
		.out_key2      (out_key2),
		.out_key3      (out_key3),
		.out_key4      (out_key4),
		.out_key5      (out_key5),
		.accepted      (accepted),
		.transport_idle(transport_idle),
		.overflow_count(overflow_count),
		.failed_count  (failed_count)
	);

endmodule

@@ tb/hkrq_checker.sv @@
// Report checker for the HID key report queue: watches both channels,
// predicts each result from the accepted request and compares field by field.
// Depends on hkrq_pkg for the function codes.
`timescale 1ns / 100ps

module hkrq_checker #(
	parameter int unsigned MAX_HELD    = 128,
	parameter int unsigned QUEUE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [3:0]  func,
	input  logic [7:0]  key_code,
	input  logic [7:0]  modifier_in,
	input  logic [7:0]  raw_key0,
	input  logic [7:0]  raw_key1,
	input  logic [7:0]  raw_key2,
	input  logic [7:0]  raw_key3,
	input  logic [7:0]  raw_key4,
	input  logic [7:0]  raw_key5,
	input  logic        host_mounted,
	input  logic        link_ready,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        send_valid,
	input  logic [7:0]  out_modifier,
	input  logic [7:0]  out_key0,
	input  logic [7:0]  out_key1,
	input  logic [7:0]  out_key2,
	input  logic [7:0]  out_key3,
	input  logic [7:0]  out_key4,
	input  logic [7:0]  out_key5,
	input  logic        accepted,
	input  logic        transport_idle,
	input  logic [31:0] overflow_count,
	input  logic [31:0] failed_count,
	output int          fail_count,
	output int          pending_count
);

	typedef logic [6:0][7:0] snap_t;

	typedef struct {
		logic        sent;
		snap_t       rep;
		logic        ok;
		logic        idle;
		logic [31:0] ovf;
		logic [31:0] fails;
	} key_report_t;

	logic [7:0]  presses [256];
	logic [7:0]  held [MAX_HELD];
	int unsigned held_n;
	logic [7:0]  want_mod;
	logic        dirty;
	snap_t       snaps [QUEUE_DEPTH];
	int unsigned rd_ptr, wr_ptr, fill;
	logic        busy, resync;
	logic [31:0] ovf_total, fail_total;
	logic        mounted, ready, sent_now;
	snap_t       sent_rep;
	key_report_t reports_due [$];

	function automatic snap_t desired_report();
		snap_t r;
		r = '0;
		r[0] = want_mod;
		for (int i = 0; i < held_n && i < hkrq_pkg::KEY_SLOTS; i++)
			r[1 + i] = held[i];
		return r;
	endfunction

	function automatic logic push_snap(snap_t r);
		if (fill != 0 && snaps[(wr_ptr + QUEUE_DEPTH - 1) % QUEUE_DEPTH] == r)
			return 1'b1;
		if (fill >= QUEUE_DEPTH) begin
			ovf_total++;
			resync = 1'b1;
			return 1'b0;
		end
		snaps[wr_ptr] = r;
		wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
		fill++;
		return 1'b1;
	endfunction

	function automatic logic queue_want();
		if (!mounted) begin
			resync = 1'b1;
			return 1'b1;
		end
		return push_snap(desired_report());
	endfunction

	function automatic void try_resync();
		if (!resync || !mounted || fill >= QUEUE_DEPTH)
			return;
		resync = 1'b0;
		if (!queue_want())
			resync = 1'b1;
	endfunction

	function automatic logic send_head();
		try_resync();
		if (busy || fill == 0 || !mounted || !ready)
			return 1'b0;
		sent_rep = snaps[rd_ptr];
		sent_now = 1'b1;
		busy = 1'b1;
		return 1'b1;
	endfunction

	function automatic void press_key(int unsigned k);
		logic [7:0] m;
		if (k == 0 || presses[k] == hkrq_pkg::COUNT_MAX)
			return;
		presses[k]++;
		if (presses[k] > 1)
			return;
		if (k >= 8'hE0 && k <= 8'hE7) begin
			m = 8'd1 << (k - 8'hE0);
			if ((want_mod & m) == 0) begin
				want_mod |= m;
				dirty = 1'b1;
			end
			return;
		end
		if (held_n < MAX_HELD) begin
			held[held_n] = 8'(k);
			held_n++;
			dirty = 1'b1;
		end else
			presses[k] = 8'd0;
	endfunction

	function automatic void release_key(int unsigned k);
		logic [7:0] m;
		if (k == 0 || presses[k] == 0)
			return;
		presses[k]--;
		if (presses[k] > 0)
			return;
		if (k >= 8'hE0 && k <= 8'hE7) begin
			m = 8'd1 << (k - 8'hE0);
			if ((want_mod & m) != 0) begin
				want_mod &= ~m;
				dirty = 1'b1;
			end
			return;
		end
		for (int i = 0; i < held_n; i++)
			if (held[i] == k) begin
				for (int j = i; j + 1 < held_n; j++)
					held[j] = held[j + 1];
				held_n--;
				held[held_n] = 8'd0;
				dirty = 1'b1;
				return;
			end
	endfunction

	function automatic key_report_t predict_report(logic [3:0] f, logic [7:0] k, snap_t raw);
		key_report_t e;
		logic ok, show;
		snap_t shown;
		ok = 1'b0;
		show = 1'b0;
		shown = '0;
		sent_now = 1'b0;
		sent_rep = '0;
		case (f)
			hkrq_pkg::FN_PRESS: press_key(k);
			hkrq_pkg::FN_RELEASE: release_key(k);
			hkrq_pkg::FN_REL_ALL: begin
				want_mod = 8'd0;
				dirty = 1'b0;
				for (int i = 0; i < MAX_HELD; i++) held[i] = 8'd0;
				for (int i = 0; i < 256; i++) presses[i] = 8'd0;
				held_n = 0;
				// keep the in-flight head, drop the rest
				if (busy && fill != 0) begin
					wr_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
					fill = 1;
				end else begin
					rd_ptr = 0;
					wr_ptr = 0;
					fill = 0;
					busy = 1'b0;
				end
				resync = 1'b0;
				ok = queue_want();
				void'(send_head());
			end
			hkrq_pkg::FN_FLUSH: begin
				if (dirty) begin
					dirty = 1'b0;
					void'(queue_want());
				end
				ok = send_head();
			end
			hkrq_pkg::FN_RAW:
				if (mounted && push_snap(raw)) begin
					void'(send_head());
					ok = 1'b1;
				end
			hkrq_pkg::FN_COMPLETE:
				if (busy && fill != 0) begin
					ok = 1'b1;
					busy = 1'b0;
					rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
					fill--;
					try_resync();
					void'(send_head());
				end
			hkrq_pkg::FN_FAILED:
				if (busy) begin
					ok = 1'b1;
					busy = 1'b0;
					fail_total++;
					void'(send_head());
				end
			hkrq_pkg::FN_UNMOUNT: begin
				rd_ptr = 0;
				wr_ptr = 0;
				fill = 0;
				busy = 1'b0;
				dirty = 1'b0;
				resync = 1'b1;
			end
			hkrq_pkg::FN_READ: begin
				shown = desired_report();
				show = 1'b1;
				ok = 1'b1;
			end
			default: ;
		endcase
		e.sent = sent_now;
		e.rep = sent_now ? sent_rep : (show ? shown : '0);
		e.ok = ok;
		e.idle = !mounted || (!dirty && !busy && fill == 0 && !resync);
		e.ovf = ovf_total;
		e.fails = fail_total;
		return e;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_report_t e;
		snap_t raw, got;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) presses[i] = 8'd0;
			for (int i = 0; i < MAX_HELD; i++) held[i] = 8'd0;
			held_n = 0;
			want_mod = 8'd0;
			dirty = 1'b0;
			rd_ptr = 0;
			wr_ptr = 0;
			fill = 0;
			busy = 1'b0;
			resync = 1'b0;
			ovf_total = 32'd0;
			fail_total = 32'd0;
			reports_due.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {out_key5, out_key4, out_key3, out_key2, out_key1, out_key0,
					out_modifier};
				if (reports_due.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					e = reports_due.pop_front();
					check_field("send_valid", 32'(e.sent), 32'(send_valid));
					check_field("out_modifier", 32'(e.rep[0]), 32'(got[0]));
					for (int i = 1; i < 7; i++)
						check_field($sformatf("out_key%0d", i - 1), 32'(e.rep[i]),
							32'(got[i]));
					check_field("accepted", 32'(e.ok), 32'(accepted));
					check_field("transport_idle", 32'(e.idle), 32'(transport_idle));
					check_field("overflow_count", e.ovf, overflow_count);
					check_field("failed_count", e.fails, failed_count);
				end
			end
			if (in_valid && !in_stall) begin
				mounted = host_mounted;
				ready = link_ready;
				raw = {raw_key5, raw_key4, raw_key3, raw_key2, raw_key1, raw_key0,
					modifier_in};
				reports_due.push_back(predict_report(func, key_code, raw));
			end
			pending_count = reports_due.size();
		end
	end
endmodule

@@ tb/testbench.sv @@
// Stimulus and verdict for the HID key report queue core.
// Depends on hkrq_pkg, hid_key_report_queue_core and hkrq_checker.
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned CYCLE_LIMIT = 2000000;

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [3:0]  func;
	logic [7:0]  key_code, modifier_in;
	logic [7:0]  raw_key0, raw_key1, raw_key2, raw_key3, raw_key4, raw_key5;
	logic        host_mounted, link_ready;
	logic        send_valid, accepted, transport_idle;
	logic [7:0]  out_modifier, out_key0, out_key1, out_key2, out_key3, out_key4, out_key5;
	logic [31:0] overflow_count, failed_count;
	int          fail_count, pending_count;
	int unsigned cycles;
	logic        quiet, hold_off;

	hid_key_report_queue_core DUT (.*);
	hkrq_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off, none at the end
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
				wait (!hold_off);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(logic [3:0] f, logic [7:0] k, logic [55:0] raw,
		logic mnt, logic rdy);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		key_code <= k;
		{raw_key5, raw_key4, raw_key3, raw_key2, raw_key1, raw_key0, modifier_in} <= raw;
		host_mounted <= mnt;
		link_ready <= rdy;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [7:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1, 2: return 8'hE0 + 8'($urandom_range(0, 7));
			3: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(4, 12));
		endcase
	endfunction

	initial begin
		logic [3:0] f;
		logic [55:0] raw;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = hkrq_pkg::FN_READ;
		key_code = 8'd0;
		{raw_key5, raw_key4, raw_key3, raw_key2, raw_key1, raw_key0, modifier_in} = '0;
		host_mounted = 1'b1;
		link_ready = 1'b1;
		quiet = 1'b0;
		hold_off = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each function, the odd cases
		send_request(hkrq_pkg::FN_PRESS, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_PRESS, 8'hE0, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_PRESS, 8'hE7, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_PRESS, 8'hFF, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_PRESS, 8'h04, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_READ, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_FLUSH, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_FLUSH, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_COMPLETE, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_COMPLETE, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_FAILED, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_RELEASE, 8'h55, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_RELEASE, 8'hFF, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_RAW, 8'h00, {56{1'b1}}, 1'b1, 1'b0);
		send_request(hkrq_pkg::FN_RAW, 8'h00, {56{1'b1}}, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_FAILED, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_RAW, 8'h00, '0, 1'b0, 1'b1);
		send_request(hkrq_pkg::FN_REL_ALL, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_REL_ALL, 8'h00, '0, 1'b0, 1'b0);
		send_request(hkrq_pkg::FN_UNMOUNT, 8'h00, '0, 1'b0, 1'b0);
		send_request(4'd9, 8'h00, '0, 1'b1, 1'b1);
		send_request(4'd15, 8'hFF, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_FLUSH, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_COMPLETE, 8'h00, '0, 1'b1, 1'b1);

		// saturate one count, fill the held list past its limit
		repeat (256) send_request(hkrq_pkg::FN_PRESS, 8'h2A, '0, 1'b1, 1'b1);
		for (int k = 1; k < 140; k++) send_request(hkrq_pkg::FN_PRESS, k[7:0], '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_FLUSH, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_RELEASE, 8'h01, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_READ, 8'h00, '0, 1'b1, 1'b1);
		// overflow the snapshot queue with the link busy, under a long hold-off
		hold_off = 1'b1;
		for (int i = 0; i < 140; i++)
			send_request(hkrq_pkg::FN_RAW, 8'h00, {$urandom, 24'(i)}, 1'b1, 1'b0);
		hold_off = 1'b0;
		send_request(hkrq_pkg::FN_FLUSH, 8'h00, '0, 1'b1, 1'b1);
		repeat (3) send_request(hkrq_pkg::FN_COMPLETE, 8'h00, '0, 1'b1, 1'b1);
		send_request(hkrq_pkg::FN_REL_ALL, 8'h00, '0, 1'b1, 1'b1);

		// random: mostly typing sessions with a live link
		for (int i = 0; i < 750; i++) begin
			if (i == 650) quiet = 1'b1;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: f = hkrq_pkg::FN_PRESS;
				6, 7, 8, 9: f = hkrq_pkg::FN_RELEASE;
				10, 11: f = hkrq_pkg::FN_FLUSH;
				12: f = hkrq_pkg::FN_RAW;
				13, 14: f = hkrq_pkg::FN_COMPLETE;
				15: f = hkrq_pkg::FN_FAILED;
				16: f = hkrq_pkg::FN_READ;
				17: f = ($urandom_range(0, 3) == 0) ? hkrq_pkg::FN_UNMOUNT :
					hkrq_pkg::FN_REL_ALL;
				18: f = 4'($urandom_range(0, 15));
				default: f = hkrq_pkg::FN_FLUSH;
			endcase
			raw = 56'({$urandom, $urandom});
			send_request(f, pick_key(), raw, $urandom_range(0, 9) != 0,
				$urandom_range(0, 3) != 0);
		end
		in_valid <= 1'b0;

		wait (pending_count == 0);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
